// File: design/assert_macros.svh
// Assertion macros for the eye aspect ratio design files.
// Depends on nothing; included by files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: design/ear_pkg.sv
// Package for the eye aspect ratio blink detector: widths and constants.
// Depends on nothing; used by the top level and ear_sqrt.
package ear_pkg;
  localparam int COORD_BITS_DEF = 12;
  localparam int EAR_BITS       = 16;
  localparam int EAR_FRAC       = 12;
  localparam int DIST_FRAC      = 8;
  localparam logic [EAR_BITS-1:0] EAR_MAX       = 16'hFFFF;
  localparam logic [EAR_BITS-1:0] THRESH_RESET  = 16'd901;
endpackage

// File: design/eye_aspect_ratio_blink_top.sv
// Top level of the eye aspect ratio blink detector: squares, roots, divide.
// Depends on ear_pkg, ear_sqrt and assert_macros.svh.
//
//  channel | direction | handshake       | payload
//  in_     | input     | valid / stall   | six landmark points
//  out_    | output    | valid / stall   | aspect_ratio, blink, degenerate
//  cfg_    | input     | valid / ready   | blink threshold, Q4.12
//
// One word enters per cycle unless a stall freezes the pipeline; the stages are
// three front stages, one square root stage per root bit (COORD_BITS + 9)
// and one divider stage per quotient bit (COORD_BITS + 22).
// The whole pipeline advances together; a stall on a valid output word freezes
// every stage, while bubbles keep moving.
// Reset clears the valid bits and loads the threshold with 0.22 in Q4.12.
`include "assert_macros.svh"
module eye_aspect_ratio_blink_top
  import ear_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_BITS-1:0] in_outer_corner_x,
  input  logic [COORD_BITS-1:0] in_outer_corner_y,
  input  logic [COORD_BITS-1:0] in_upper_a_x,
  input  logic [COORD_BITS-1:0] in_upper_a_y,
  input  logic [COORD_BITS-1:0] in_upper_b_x,
  input  logic [COORD_BITS-1:0] in_upper_b_y,
  input  logic [COORD_BITS-1:0] in_inner_corner_x,
  input  logic [COORD_BITS-1:0] in_inner_corner_y,
  input  logic [COORD_BITS-1:0] in_lower_b_x,
  input  logic [COORD_BITS-1:0] in_lower_b_y,
  input  logic [COORD_BITS-1:0] in_lower_a_x,
  input  logic [COORD_BITS-1:0] in_lower_a_y,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [EAR_BITS-1:0]   cfg_blink_threshold,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [EAR_BITS-1:0]   out_aspect_ratio,
  output logic                  out_blink,
  output logic                  out_degenerate
);
  localparam int SQ_BITS  = 2 * COORD_BITS + 1;           // dx^2 + dy^2
  localparam int RAD_BITS = SQ_BITS + 1 + 2 * DIST_FRAC;  // even width
  localparam int D_BITS   = RAD_BITS / 2;                  // distance width
  localparam int N_BITS   = D_BITS + 1 + EAR_FRAC;        // dividend width
  localparam int Q_BITS   = N_BITS;                        // quotient bits
  localparam int DV_BITS  = D_BITS + 1;                    // divisor 2h
  localparam int LAT      = 3 + D_BITS + Q_BITS;

  logic en;
  logic [LAT-1:0] vld_r;
  logic [EAR_BITS-1:0] thresh_r;

  assign en        = !(out_stall && vld_r[LAT-1]);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      thresh_r <= THRESH_RESET;
    end else begin
      if (en) vld_r <= {vld_r[LAT-2:0], in_valid};
      if (cfg_valid) thresh_r <= cfg_blink_threshold;
    end
  end

  // Stage 1: absolute differences.
  logic [COORD_BITS-1:0] dax_r, day_r, dbx_r, dby_r, dhx_r, dhy_r;
  function automatic logic [COORD_BITS-1:0] adiff(input logic [COORD_BITS-1:0] a,
                                                  input logic [COORD_BITS-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction
  always_ff @(posedge clk) begin
    if (en) begin
      dax_r <= adiff(in_upper_a_x, in_lower_a_x);
      day_r <= adiff(in_upper_a_y, in_lower_a_y);
      dbx_r <= adiff(in_upper_b_x, in_lower_b_x);
      dby_r <= adiff(in_upper_b_y, in_lower_b_y);
      dhx_r <= adiff(in_outer_corner_x, in_inner_corner_x);
      dhy_r <= adiff(in_outer_corner_y, in_inner_corner_y);
    end
  end

  // Stage 2: squares; stage 3: sums shifted into root radicands.
  logic [2*COORD_BITS-1:0] sax_r, say_r, sbx_r, sby_r, shx_r, shy_r;
  logic [RAD_BITS-1:0] rada_r, radb_r, radh_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sax_r <= dax_r * dax_r;
      say_r <= day_r * day_r;
      sbx_r <= dbx_r * dbx_r;
      sby_r <= dby_r * dby_r;
      shx_r <= dhx_r * dhx_r;
      shy_r <= dhy_r * dhy_r;
      rada_r <= {1'b0, SQ_BITS'(sax_r) + SQ_BITS'(say_r), (2*DIST_FRAC)'(0)};
      radb_r <= {1'b0, SQ_BITS'(sbx_r) + SQ_BITS'(sby_r), (2*DIST_FRAC)'(0)};
      radh_r <= {1'b0, SQ_BITS'(shx_r) + SQ_BITS'(shy_r), (2*DIST_FRAC)'(0)};
    end
  end

  logic [D_BITS-1:0] va, vb, vh;
  ear_sqrt #(.IN_BITS(RAD_BITS)) u_sqrt_a (.clk(clk), .en(en), .rad(rada_r), .root(va));
  ear_sqrt #(.IN_BITS(RAD_BITS)) u_sqrt_b (.clk(clk), .en(en), .rad(radb_r), .root(vb));
  ear_sqrt #(.IN_BITS(RAD_BITS)) u_sqrt_h (.clk(clk), .en(en), .rad(radh_r), .root(vh));

  // Restoring divider, one quotient bit per stage, dividend bits fed MSB first.
  logic [N_BITS-1:0]  num_s [Q_BITS+1];
  logic [DV_BITS:0]   rem_s [Q_BITS+1];
  logic [DV_BITS-1:0] den_s [Q_BITS+1];
  logic [Q_BITS-1:0]  quo_s [Q_BITS+1];
  always_comb begin
    num_s[0] = {(D_BITS+1)'(va) + (D_BITS+1)'(vb), EAR_FRAC'(0)};
    rem_s[0] = '0;
    den_s[0] = {vh, 1'b0};
    quo_s[0] = '0;
  end
  for (genvar s = 0; s < Q_BITS; s++) begin : g_div
    logic [DV_BITS:0]   r_nxt;
    logic [Q_BITS-1:0]  q_nxt;
    logic [N_BITS-1:0]  n_r;
    logic [DV_BITS:0]   r_r;
    logic [DV_BITS-1:0] d_r;
    logic [Q_BITS-1:0]  q_r;
    always_comb begin
      r_nxt = {rem_s[s][DV_BITS-1:0], num_s[s][N_BITS-1]};
      if (r_nxt >= {1'b0, den_s[s]}) begin
        r_nxt = r_nxt - {1'b0, den_s[s]};
        q_nxt = {quo_s[s][Q_BITS-2:0], 1'b1};
      end else begin
        q_nxt = {quo_s[s][Q_BITS-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        n_r <= {num_s[s][N_BITS-2:0], 1'b0};
        r_r <= r_nxt;
        d_r <= den_s[s];
        q_r <= q_nxt;
      end
    end
    always_comb begin
      num_s[s+1] = n_r;
      rem_s[s+1] = r_r;
      den_s[s+1] = d_r;
      quo_s[s+1] = q_r;
    end
  end

  logic degen, sat;
  logic [EAR_BITS-1:0] ratio;
  always_comb begin
    degen = (den_s[Q_BITS] == '0);
    sat   = degen || (quo_s[Q_BITS][Q_BITS-1:EAR_BITS] != '0);
    ratio = sat ? EAR_MAX : quo_s[Q_BITS][EAR_BITS-1:0];
  end
  assign out_aspect_ratio = ratio;
  assign out_degenerate   = degen;
  assign out_blink        = !degen && (ratio < thresh_r);

  `ASSERT_IMP(a_blink_not_degen, clk, rst_n, out_valid && out_blink, !out_degenerate, "blink on degenerate eye")
  `ASSERT_IMP(a_degen_sat, clk, rst_n, out_valid && out_degenerate, out_aspect_ratio == EAR_MAX, "degenerate ratio not saturated")
  `ASSERT_NXT(a_stall_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_aspect_ratio), "stalled word changed")
endmodule

// File: design/ear_sqrt.sv
// Pipelined integer square root, one restoring step per stage.
// Depends on ear_pkg; used by the top level, three instances.
module ear_sqrt
  import ear_pkg::*;
#(
  parameter int IN_BITS = 42
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [IN_BITS-1:0]   rad,
  output logic [IN_BITS/2-1:0] root
);
  localparam int RB = IN_BITS / 2;
  // Per stage: remaining radicand, partial remainder and root so far.
  logic [IN_BITS-1:0] rad_r [RB+1];
  logic [RB+1:0]      rem_r [RB+1];
  logic [RB-1:0]      q_r   [RB+1];

  always_comb begin
    rad_r[0] = rad;
    rem_r[0] = '0;
    q_r[0]   = '0;
  end

  for (genvar s = 0; s < RB; s++) begin : g_step
    logic [RB+1:0]      trial;
    logic [RB+1:0]      rem_nxt;
    logic [RB-1:0]      q_nxt;
    logic [IN_BITS-1:0] rad_nxt;
    logic [RB+1:0]      rem_cur_r;
    logic [RB-1:0]      q_cur_r;
    logic [IN_BITS-1:0] rad_cur_r;
    always_comb begin
      rem_nxt = {rem_r[s][RB-1:0], rad_r[s][IN_BITS-1 -: 2]};
      trial   = {q_r[s], 2'b01};
      rad_nxt = {rad_r[s][IN_BITS-3:0], 2'b00};
      if (rem_nxt >= trial) begin
        rem_nxt = rem_nxt - trial;
        q_nxt   = {q_r[s][RB-2:0], 1'b1};
      end else begin
        q_nxt   = {q_r[s][RB-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_cur_r <= rem_nxt;
        q_cur_r   <= q_nxt;
        rad_cur_r <= rad_nxt;
      end
    end
    always_comb begin
      rem_r[s+1] = rem_cur_r;
      q_r[s+1]   = q_cur_r;
      rad_r[s+1] = rad_cur_r;
    end
  end

  assign root = q_r[RB];
endmodule
